// ===== hdl/dsp_float_ieee_converter_top_macros.svh =====
// ----------------------------------------------------------------------------
// float converter assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef DSP_FLOAT_IEEE_CONVERTER_TOP_MACROS_SVH
`define DSP_FLOAT_IEEE_CONVERTER_TOP_MACROS_SVH

// same-cycle implication
`define DFIC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error("dfic assertion failed");

// delayed implication
`define DFIC_ASSERT_DLY(label, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> ##n (cons)) else $error("dfic assertion failed");

`endif

// ===== hdl/dfic_pkg.sv =====
// ----------------------------------------------------------------------------
// float converter package
// shared constants and inter-stage types of the float format converter
// ----------------------------------------------------------------------------
package dfic_pkg;

	localparam logic ACT_DSP_TO_IEEE = 1'b0;
	localparam logic ACT_IEEE_TO_DSP = 1'b1;

	localparam logic [7:0] EXP_MAX  = 8'hff;
	localparam logic [7:0] EXP_ZERO = 8'h00;

	typedef struct packed {
		logic        action;
		logic        sign;
		logic [31:0] mant;
		logic [7:0]  expo;
		logic        adj;
	} dfic_s1_t;

	typedef struct packed {
		logic        action;
		logic        sign;
		logic [31:0] mant;
		logic [7:0]  expo;
		logic        ovf;
		logic        zero;
	} dfic_s2_t;

endpackage

// ===== hdl/dfic_prep.sv =====
// ----------------------------------------------------------------------------
// float converter stage 1
// field split, mantissa negation and exponent adjust decision
// ----------------------------------------------------------------------------
module dfic_prep import dfic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        action,
	input  logic [31:0] word_in,
	output logic        valid_s1,
	output dfic_s1_t    data_s1
);

	dfic_s1_t    nxt;
	logic        sign;
	logic [22:0] frac;
	logic [22:0] frac_neg;
	logic [31:0] mant;
	logic [31:0] mant_neg;

	always_comb begin
		sign     = word_in[31];
		frac     = word_in[30:8];
		frac_neg = 23'd0 - frac;
		mant     = {1'b0, word_in[22:0], 8'd0};
		mant_neg = 32'd0 - mant;
		nxt.action = action;
		nxt.sign   = sign;
		if (action == ACT_DSP_TO_IEEE) begin
			nxt.mant = {9'd0, (sign ? frac_neg : frac)};
			nxt.expo = word_in[7:0];
			nxt.adj  = (word_in[7:0] != EXP_ZERO) && (!sign || (frac_neg != 23'd0));
		end else begin
			nxt.mant = sign ? mant_neg : mant;
			nxt.expo = word_in[30:23];
			nxt.adj  = (!sign && (word_in[30:23] != EXP_ZERO)) ||
				(sign && (word_in[22:0] != 23'd0));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

endmodule

// ===== hdl/dfic_expadj.sv =====
// ----------------------------------------------------------------------------
// float converter stage 2
// exponent increment or decrement with saturation and zero detect
// ----------------------------------------------------------------------------
module dfic_expadj import dfic_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     valid_s1,
	input  dfic_s1_t data_s1,
	output logic     valid_s2,
	output dfic_s2_t data_s2
);

	dfic_s2_t nxt;

	always_comb begin
		nxt.action = data_s1.action;
		nxt.sign   = data_s1.sign;
		nxt.mant   = data_s1.mant;
		nxt.expo   = data_s1.expo;
		nxt.ovf    = 1'b0;
		nxt.zero   = 1'b0;
		if (data_s1.action == ACT_DSP_TO_IEEE) begin
			if (data_s1.adj) begin
				nxt.expo = data_s1.expo - 8'd1;
			end
			nxt.zero = (nxt.expo == EXP_ZERO);
		end else if (data_s1.adj) begin
			if (data_s1.expo == EXP_MAX) begin
				nxt.ovf = 1'b1;
			end else begin
				nxt.expo = data_s1.expo + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		data_s2 <= nxt;
	end

endmodule

// ===== hdl/dsp_float_ieee_converter_top.sv =====
// ----------------------------------------------------------------------------
// dsp float / ieee single converter, top level
// start passes the valid registers of stage 1, stage 2 and the output stage to done; one word per cycle, busy stays low
// results cannot be held off, so the pipeline never stalls
// reset clears the stage valid bits only, no results after reset
// ----------------------------------------------------------------------------
module dsp_float_ieee_converter_top import dfic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [31:0] word_in,
	output logic        done,
	output logic [31:0] word_out,
	output logic        overflow
);

	`include "dsp_float_ieee_converter_top_macros.svh"

	logic        valid_s1;
	dfic_s1_t    data_s1;
	logic        valid_s2;
	dfic_s2_t    data_s2;
	logic        valid_s3;
	logic [31:0] word_s3;
	logic        ovf_s3;
	logic [31:0] word_nxt;

	assign busy = 1'b0;

	dfic_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.action   (action),
		.word_in  (word_in),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	dfic_expadj u_expadj (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	always_comb begin
		if (data_s2.action == ACT_DSP_TO_IEEE) begin
			word_nxt = data_s2.zero ? 32'd0 :
				{data_s2.sign, data_s2.expo, data_s2.mant[22:0]};
		end else begin
			word_nxt = {data_s2.sign | data_s2.mant[31], data_s2.mant[30:8], data_s2.expo};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		word_s3 <= word_nxt;
		ovf_s3  <= data_s2.ovf;
	end

	assign done     = valid_s3;
	assign word_out = word_s3;
	assign overflow = ovf_s3;

	`DFIC_ASSERT_DLY(a_start_gives_done, start, 3, done)
	`DFIC_ASSERT_DLY(a_idle_gives_no_done, !start, 3, !done)
	`DFIC_ASSERT_IMP(a_ovf_saturates, done && overflow, word_out[7:0] == EXP_MAX)

endmodule
